>>> rtl/pfe_pkg.sv
// Shared types, constants and key-square helpers for the Playfair stream encryptor.
package pfe_pkg;

  // Geometry of the key square and letter coding.
  localparam int SqDim   = 5;
  localparam int LetW    = 5;
  localparam int RowW    = SqDim * LetW;
  localparam int PosW    = 3;
  localparam int CfgIdxW = 3;

  // Default depth of the job queue between front and back.
  localparam int DefQueueDepth = 2;

  localparam logic [LetW-1:0] LetterX = 5'd23;
  localparam logic [LetW-1:0] LetterI = 5'd8;
  localparam logic [LetW-1:0] LetterJ = 5'd9;
  localparam logic [7:0]      CharA   = 8'd97;
  localparam logic [7:0]      CharZ   = 8'd122;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } opcode_e;

  typedef logic [RowW-1:0]  row_t;
  typedef row_t [SqDim-1:0] square_t;

  // Square after reset, row 0 in the low slot.
  localparam square_t SquareReset = {25'd27025109, 25'd21613104, 25'd16201099,
                                     25'd10755269, 25'd4294688};

  typedef struct packed {
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
  } pos_t;

  // One pair of letters to encrypt, as handed from front to back.
  typedef struct packed {
    logic [LetW-1:0] first;
    logic [LetW-1:0] second;
    logic            last;
    logic            empty;
  } job_t;

  function automatic logic [LetW-1:0] sq_cell(input square_t sq,
                                              input logic [PosW-1:0] r,
                                              input logic [PosW-1:0] c);
    return sq[r][LetW*c +: LetW];
  endfunction

  // Step one place along a row or column, wrapping at the edge.
  function automatic logic [PosW-1:0] sq_next(input logic [PosW-1:0] p);
    return (p == PosW'(SqDim - 1)) ? '0 : p + PosW'(1);
  endfunction

  // First match in row-major order; row 0, column 0 when there is none.
  function automatic pos_t sq_locate(input square_t sq, input logic [LetW-1:0] letter);
    pos_t p;
    p = '0;
    for (int i = SqDim - 1; i >= 0; i--) begin
      for (int k = SqDim - 1; k >= 0; k--) begin
        if (sq_cell(sq, PosW'(i), PosW'(k)) == letter) begin
          p.row = PosW'(i);
          p.col = PosW'(k);
        end
      end
    end
    return p;
  endfunction

endpackage

>>> rtl/pfe_if.sv
// Channel interfaces: plaintext input, ciphertext output and register writes.
interface pfe_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] char_in;

  modport source (output valid, output opcode, output char_in, input ready);
  modport sink   (input valid, input opcode, input char_in, output ready);
endinterface

interface pfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_char;
  logic       last_of_message;
  logic       empty_res;

  modport source (output valid, output cipher_char, output last_of_message,
                  output empty_res, input ready);
  modport sink   (input valid, input cipher_char, input last_of_message,
                  input empty_res, output ready);
endinterface

interface pfe_cfg_if import pfe_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [RowW-1:0]    wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/playfair_stream_encrypt.sv
// Top level of the Playfair stream encryptor: key-square registers, front end, queue, back end.
// Path: a beat that completes a pair passes through the job queue, the locate stage and the emit stage.
// Throughput: one input beat per cycle while the job queue is not full; a pair takes two output
// beats on the one-wide result channel (one beat for an empty end result), from the emit stage.
// Reset: the key square returns to its default rows, no letter is pending, all stages empty.
module playfair_stream_encrypt import pfe_pkg::*; #(
  parameter int QueueDepth = DefQueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfe_in_if.sink    in_i,
  pfe_cfg_if.sink   cfg_i,
  pfe_out_if.source out_o
);

  square_t square_q;
  logic    q_full, q_push, q_valid, q_pop;
  job_t    q_in, q_head;

  // Key-square registers; writes to an index past the last row are ignored.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      square_q <= SquareReset;
    end else if (cfg_i.valid && cfg_i.ready && (cfg_i.index < CfgIdxW'(SqDim))) begin
      square_q[cfg_i.index] <= cfg_i.wdata;
    end
  end

  pfe_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .square_i (square_q),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .job_o    (q_in)
  );

  pfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  pfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .square_i     (square_q),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_o        (out_o)
  );

endmodule

>>> rtl/pfe_front.sv
// Front end: filters and maps input bytes, pairs letters and issues pair jobs.
module pfe_front import pfe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  square_t square_i,
  pfe_in_if.sink  in_i,
  input  logic    q_full_i,
  output logic    push_o,
  output job_t    job_o
);

  logic            pend_valid_q, pend_valid_d;
  logic [LetW-1:0] pend_letter_q, pend_letter_d;
  logic            accept;
  logic            is_letter;
  logic [7:0]      offset;
  logic [LetW-1:0] letter;
  logic [LetW-1:0] below_x;
  pos_t            pos_x;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Map the byte to a letter index, folding j onto i.
  assign is_letter = (in_i.char_in >= CharA) && (in_i.char_in <= CharZ);
  assign offset    = in_i.char_in - CharA;
  assign letter    = (offset[LetW-1:0] == LetterJ) ? LetterI : offset[LetW-1:0];

  // Filler for a doubled x: the entry just below x in the square.
  assign pos_x   = sq_locate(square_i, LetterX);
  assign below_x = sq_cell(square_i, sq_next(pos_x.row), pos_x.col);

  // Classify the beat and decide on a job and the new pending letter.
  always_comb begin
    pend_valid_d  = pend_valid_q;
    pend_letter_d = pend_letter_q;
    push_o        = 1'b0;
    job_o.first   = pend_letter_q;
    job_o.second  = LetterX;
    job_o.last    = 1'b0;
    job_o.empty   = 1'b0;
    if (accept) begin
      if (opcode_e'(in_i.opcode) == OP_END) begin
        push_o        = 1'b1;
        job_o.last    = 1'b1;
        job_o.empty   = !pend_valid_q;
        pend_valid_d  = 1'b0;
        pend_letter_d = '0;
      end else if (is_letter) begin
        if (!pend_valid_q) begin
          pend_valid_d  = 1'b1;
          pend_letter_d = letter;
        end else if (letter == pend_letter_q) begin
          // Doubled letter: split with filler, the new letter stays pending.
          push_o       = 1'b1;
          job_o.second = (letter == LetterX) ? below_x : LetterX;
        end else begin
          push_o        = 1'b1;
          job_o.second  = letter;
          pend_valid_d  = 1'b0;
          pend_letter_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q  <= 1'b0;
      pend_letter_q <= '0;
    end else begin
      pend_valid_q  <= pend_valid_d;
      pend_letter_q <= pend_letter_d;
    end
  end

endmodule

>>> rtl/pfe_queue.sv
// Small job queue that decouples the front end from the encryption back end.
module pfe_queue import pfe_pkg::*; #(
  parameter int Depth = DefQueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t head_o
);

  // Depth must be a power of two, at least 2, so the pointers wrap naturally.
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  job_t             mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + AddrW'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (!push_i && do_pop) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job queue written while full");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("job queue count out of range");

endmodule

>>> rtl/pfe_back.sv
// Back end: locates a pair in the key square, applies the Playfair rules, sends two beats (one if empty).
module pfe_back import pfe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  square_t square_i,
  input  logic    head_valid_i,
  input  job_t    head_i,
  output logic    pop_o,
  pfe_out_if.source out_o
);

  // Locate stage.
  logic            l_valid_q;
  pos_t            l_pa_q, l_pb_q;
  logic            l_last_q, l_empty_q;
  // Emit stage.
  logic            e_valid_q;
  logic [LetW-1:0] e_ea_q, e_eb_q;
  logic            e_last_q, e_empty_q, e_beat_q;

  logic            out_take, e_done, e_free, l_adv, l_free;
  logic [LetW-1:0] ea, eb, cur_letter;

  assign out_take = out_o.valid && out_o.ready;
  assign e_done   = out_take && (e_empty_q || e_beat_q);
  assign e_free   = !e_valid_q || e_done;
  assign l_adv    = l_valid_q && e_free;
  assign l_free   = !l_valid_q || l_adv;
  assign pop_o    = head_valid_i && l_free;

  // Playfair rules on the located positions.
  always_comb begin
    if (l_pa_q.row == l_pb_q.row) begin
      ea = sq_cell(square_i, l_pa_q.row, sq_next(l_pa_q.col));
      eb = sq_cell(square_i, l_pb_q.row, sq_next(l_pb_q.col));
    end else if (l_pa_q.col == l_pb_q.col) begin
      ea = sq_cell(square_i, sq_next(l_pa_q.row), l_pa_q.col);
      eb = sq_cell(square_i, sq_next(l_pb_q.row), l_pb_q.col);
    end else begin
      ea = sq_cell(square_i, l_pa_q.row, l_pb_q.col);
      eb = sq_cell(square_i, l_pb_q.row, l_pa_q.col);
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      l_pa_q    <= sq_locate(square_i, head_i.first);
      l_pb_q    <= sq_locate(square_i, head_i.second);
      l_last_q  <= head_i.last;
      l_empty_q <= head_i.empty;
    end
    if (l_adv) begin
      e_ea_q    <= ea;
      e_eb_q    <= eb;
      e_last_q  <= l_last_q;
      e_empty_q <= l_empty_q;
    end
  end

  // Stage occupancy and beat counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      e_beat_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        l_valid_q <= 1'b1;
      end else if (l_adv) begin
        l_valid_q <= 1'b0;
      end
      if (l_adv) begin
        e_valid_q <= 1'b1;
        e_beat_q  <= 1'b0;
      end else if (e_done) begin
        e_valid_q <= 1'b0;
        e_beat_q  <= 1'b0;
      end else if (out_take) begin
        e_beat_q <= 1'b1;
      end
    end
  end

  // Output beat: first letter, then second; an empty result is a single beat.
  assign cur_letter            = e_beat_q ? e_eb_q : e_ea_q;
  assign out_o.valid           = e_valid_q;
  assign out_o.cipher_char     = e_empty_q ? 8'd0 : CharA + {3'b000, cur_letter};
  assign out_o.last_of_message = e_last_q && (e_empty_q || e_beat_q);
  assign out_o.empty_res       = e_empty_q;

  a_empty_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_valid_q && e_empty_q) |-> !e_beat_q)
    else $error("empty result entered a second beat");

  a_locate_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (l_valid_q && !l_adv) |=> (l_valid_q && $stable(l_pa_q) && $stable(l_pb_q)))
    else $error("locate stage lost a stalled pair");

  a_pair_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && e_beat_q) |=> (!e_beat_q))
    else $error("pair emitted more than two beats");

endmodule
